>>> sv/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// Used by bracket_balance_checker_core; depends on nothing else.
`timescale 1ns / 1ps

package bbc_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_EOD  = 2'd2;

  // Report codes on the result channel.
  localparam logic [1:0] REP_NO_OPENER = 2'd0;
  localparam logic [1:0] REP_MISMATCH  = 2'd1;
  localparam logic [1:0] REP_UNCLOSED  = 2'd2;
  localparam logic [1:0] REP_DONE      = 2'd3;

  // Bracket kinds as stored on the stack.
  localparam logic [1:0] BR_PAREN = 2'd0;
  localparam logic [1:0] BR_SQUARE = 2'd1;
  localparam logic [1:0] BR_CURLY = 2'd2;

  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  report;
    logic [7:0]  bracket_char;
    logic [7:0]  open_char;
    logic [19:0] line_no;
    logic [15:0] column_no;
    logic        overflowed;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FL_RD,
    ST_FL_OUT
  } state_t;

  // Opener character for a stored bracket kind; an unused kind maps like kind mod 3.
  function automatic logic [7:0] opener_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      BR_PAREN:  c = CH_LPAREN;
      BR_SQUARE: c = CH_LSQUARE;
      BR_CURLY:  c = CH_LCURLY;
      default:   c = CH_LPAREN;
    endcase
    return c;
  endfunction

endpackage

>>> sv/bbc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; used for the bracket stack of the checker core.
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/bracket_balance_checker_core.sv
// Bracket balance checker: scans source text one word per cycle while idle
// and the result register is free, and checks that ( [ { are closed in order,
// outside strings and line comments. The opener stack lives in a
// one-port-read, one-port-write RAM of STACK_DEPTH entries. A pop refreshes the
// top-of-stack kind with a RAM read in the background, so back-to-back closers
// do not stall. At end of document each opener left on the stack is read from
// the RAM (ST_FL_RD) and then reported (ST_FL_OUT), and then comes the done
// result, with no new word taken meanwhile.
// Depends on bbc_pkg and bbc_ram.
`timescale 1ns / 1ps

module bracket_balance_checker_core #(
  parameter int STACK_DEPTH = 32,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bbc_pkg::in_word_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bbc_pkg::out_word_t out_data
);

  localparam int AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = 2 + LINE_BITS + COLUMN_BITS;

  bbc_pkg::state_t    state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic               str_r, str_nxt;
  logic               cmt_r, cmt_nxt;
  logic               prev_bs_r, prev_bs_nxt;
  logic               prev_slash_r, prev_slash_nxt;
  logic               ovf_r, ovf_nxt;
  logic [1:0]         top_kind_r, top_kind_nxt;
  logic               top_from_ram_r, top_from_ram_nxt;
  logic               out_valid_r, out_valid_nxt;
  bbc_pkg::out_word_t out_r, out_nxt;

  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;

  logic               out_free, accept;
  logic [1:0]         top_kind, rd_kind;
  logic [31:0]        line_wide, col_wide, ent_line_wide, ent_col_wide;
  logic               is_opener, is_closer, is_quote, str_flip;
  logic [1:0]         br_kind;
  logic [CNT_W-1:0]   cnt_m1, cnt_m2;

  bbc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == bbc_pkg::ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign rd_kind  = rd_data[ENTRY_W-1 -: 2];
  // After a pop the new top comes from the RAM read issued with that pop.
  assign top_kind = top_from_ram_r ? rd_kind : top_kind_r;

  assign line_wide     = 32'(line_r);
  assign col_wide      = 32'(col_r);
  assign ent_line_wide = 32'(rd_data[COLUMN_BITS +: LINE_BITS]);
  assign ent_col_wide  = 32'(rd_data[COLUMN_BITS-1:0]);

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign cnt_m2 = cnt_r - CNT_W'(2);

  always_comb begin
    is_opener = (in_data.ch == bbc_pkg::CH_LPAREN) || (in_data.ch == bbc_pkg::CH_LSQUARE) ||
                (in_data.ch == bbc_pkg::CH_LCURLY);
    is_closer = (in_data.ch == bbc_pkg::CH_RPAREN) || (in_data.ch == bbc_pkg::CH_RSQUARE) ||
                (in_data.ch == bbc_pkg::CH_RCURLY);
    is_quote  = (in_data.ch == bbc_pkg::CH_DQUOTE) || (in_data.ch == bbc_pkg::CH_SQUOTE);
    if ((in_data.ch == bbc_pkg::CH_LPAREN) || (in_data.ch == bbc_pkg::CH_RPAREN)) begin
      br_kind = bbc_pkg::BR_PAREN;
    end else if ((in_data.ch == bbc_pkg::CH_LSQUARE) || (in_data.ch == bbc_pkg::CH_RSQUARE)) begin
      br_kind = bbc_pkg::BR_SQUARE;
    end else begin
      br_kind = bbc_pkg::BR_CURLY;
    end
    str_flip = str_r ^ (is_quote && !prev_bs_r);
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    line_nxt         = line_r;
    col_nxt          = col_r;
    str_nxt          = str_r;
    cmt_nxt          = cmt_r;
    prev_bs_nxt      = prev_bs_r;
    prev_slash_nxt   = prev_slash_r;
    ovf_nxt          = ovf_r;
    top_kind_nxt     = top_kind_r;
    top_from_ram_nxt = top_from_ram_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_nxt          = out_r;
    wr_en            = 1'b0;
    wr_addr          = cnt_r[AW-1:0];
    wr_data          = {br_kind, line_r, col_r};
    rd_en            = 1'b0;
    rd_addr          = cnt_m2[AW-1:0];

    case (state_r)
      bbc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.kind)
            bbc_pkg::KIND_TEXT: begin
              prev_bs_nxt    = (in_data.ch == bbc_pkg::CH_BACKSLASH);
              prev_slash_nxt = (in_data.ch == bbc_pkg::CH_SLASH);
              if (col_r != '1) begin
                col_nxt = col_r + COLUMN_BITS'(1);
              end
              if (cmt_r) begin
                // Rest of the line is a comment.
              end else if (!str_r && prev_slash_r && (in_data.ch == bbc_pkg::CH_SLASH)) begin
                cmt_nxt = 1'b1;
              end else begin
                str_nxt = str_flip;
                if (!str_flip && is_opener) begin
                  if (cnt_r < CNT_W'(STACK_DEPTH)) begin
                    wr_en            = 1'b1;
                    cnt_nxt          = cnt_r + CNT_W'(1);
                    top_kind_nxt     = br_kind;
                    top_from_ram_nxt = 1'b0;
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end else if (!str_flip && is_closer) begin
                  if (cnt_r == '0) begin
                    out_valid_nxt        = 1'b1;
                    out_nxt.report       = bbc_pkg::REP_NO_OPENER;
                    out_nxt.bracket_char = in_data.ch;
                    out_nxt.open_char    = '0;
                    out_nxt.line_no      = line_wide[19:0];
                    out_nxt.column_no    = col_wide[15:0];
                    out_nxt.overflowed   = ovf_r;
                    out_nxt.last         = 1'b1;
                  end else if (top_kind != br_kind) begin
                    out_valid_nxt        = 1'b1;
                    out_nxt.report       = bbc_pkg::REP_MISMATCH;
                    out_nxt.bracket_char = in_data.ch;
                    out_nxt.open_char    = bbc_pkg::opener_char(top_kind);
                    out_nxt.line_no      = line_wide[19:0];
                    out_nxt.column_no    = col_wide[15:0];
                    out_nxt.overflowed   = ovf_r;
                    out_nxt.last         = 1'b1;
                  end else begin
                    cnt_nxt = cnt_m1;
                    if (cnt_r >= CNT_W'(2)) begin
                      rd_en            = 1'b1;
                      top_from_ram_nxt = 1'b1;
                    end else begin
                      top_from_ram_nxt = 1'b0;
                    end
                  end
                end
              end
            end
            bbc_pkg::KIND_EOL: begin
              col_nxt        = '0;
              str_nxt        = 1'b0;
              cmt_nxt        = 1'b0;
              prev_bs_nxt    = 1'b0;
              prev_slash_nxt = 1'b0;
              if (line_r != '1) begin
                line_nxt = line_r + LINE_BITS'(1);
              end
            end
            bbc_pkg::KIND_EOD: begin
              state_nxt = bbc_pkg::ST_FL_RD;
            end
            default: begin
              // Unused kind: ignored.
            end
          endcase
        end
      end

      bbc_pkg::ST_FL_RD: begin
        if (cnt_r != '0) begin
          rd_en     = 1'b1;
          rd_addr   = cnt_m1[AW-1:0];
          state_nxt = bbc_pkg::ST_FL_OUT;
        end else if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.report       = bbc_pkg::REP_DONE;
          out_nxt.bracket_char = '0;
          out_nxt.open_char    = '0;
          out_nxt.line_no      = '0;
          out_nxt.column_no    = '0;
          out_nxt.overflowed   = ovf_r;
          out_nxt.last         = 1'b1;
          cnt_nxt              = '0;
          line_nxt             = '0;
          col_nxt              = '0;
          str_nxt              = 1'b0;
          cmt_nxt              = 1'b0;
          prev_bs_nxt          = 1'b0;
          prev_slash_nxt       = 1'b0;
          ovf_nxt              = 1'b0;
          top_from_ram_nxt     = 1'b0;
          state_nxt            = bbc_pkg::ST_IDLE;
        end
      end

      bbc_pkg::ST_FL_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.report       = bbc_pkg::REP_UNCLOSED;
          out_nxt.bracket_char = bbc_pkg::opener_char(rd_kind);
          out_nxt.open_char    = '0;
          out_nxt.line_no      = ent_line_wide[19:0];
          out_nxt.column_no    = ent_col_wide[15:0];
          out_nxt.overflowed   = ovf_r;
          out_nxt.last         = 1'b0;
          cnt_nxt              = cnt_m1;
          state_nxt            = bbc_pkg::ST_FL_RD;
        end
      end

      default: begin
        state_nxt = bbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= bbc_pkg::ST_IDLE;
      cnt_r          <= '0;
      line_r         <= '0;
      col_r          <= '0;
      str_r          <= 1'b0;
      cmt_r          <= 1'b0;
      prev_bs_r      <= 1'b0;
      prev_slash_r   <= 1'b0;
      ovf_r          <= 1'b0;
      top_from_ram_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      line_r         <= line_nxt;
      col_r          <= col_nxt;
      str_r          <= str_nxt;
      cmt_r          <= cmt_nxt;
      prev_bs_r      <= prev_bs_nxt;
      prev_slash_r   <= prev_slash_nxt;
      ovf_r          <= ovf_nxt;
      top_from_ram_r <= top_from_ram_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_kind_r <= top_kind_nxt;
    out_r      <= out_nxt;
  end

  // The stack count never runs past the RAM depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count exceeds depth");

  // Words are taken only while idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (state_r == bbc_pkg::ST_IDLE))
    else $error("word accepted outside idle");

  // The done result leaves an empty stack behind and closes the document.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbc_pkg::ST_FL_RD && cnt_r == '0 && out_free)
    |=> (cnt_r == '0 && out_valid_r && out_r.last && !ovf_r))
    else $error("done result without cleared state");

  // A top kind taken from the RAM is only used while the stack holds entries.
  a_top_from_ram: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbc_pkg::ST_IDLE && top_from_ram_r) |-> (cnt_r != '0))
    else $error("top of stack read from an empty stack");

endmodule
